@@ rtl/gqdp_pkg.sv @@
package gqdp_pkg;

  // Sizing limits of the group and row counters
  localparam int MAX_GROUP      = 256;
  localparam int MAX_ROW_GROUPS = 64;

  // Fixed field widths
  localparam int BYTE_W        = 8;
  localparam int SCALE_W       = 16;
  localparam int FMT_W         = 1;
  localparam int GRP_LEN_W     = 9;
  localparam int ROW_GROUPS_W  = 7;
  localparam int ROW_COUNT_W   = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int PROD_W        = 16;
  localparam int PART_W        = PROD_W + 1;
  localparam int GSUM_W        = 24;
  localparam int QSCALE_W      = 24;
  localparam int CONTRIB_W     = 48;
  localparam int ROW_W         = 55;

  // Counter widths follow from the limits and the register widths
  localparam int EC_MIN_W = $clog2(MAX_GROUP + 2);
  localparam int EC_W     = (EC_MIN_W > GRP_LEN_W) ? EC_MIN_W : GRP_LEN_W;
  localparam int GC_MIN_W = $clog2(MAX_ROW_GROUPS + 1);
  localparam int GC_W     = (GC_MIN_W > ROW_GROUPS_W) ? GC_MIN_W : ROW_GROUPS_W;

  // Nibble decode constants
  localparam logic [3:0]        NIB_MASK   = 4'hf;
  localparam logic [BYTE_W-1:0] NIB_OFFSET = 8'd8;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_FORMAT     = 2'd0,
    CFG_GRP_LEN    = 2'd1,
    CFG_ROW_GROUPS = 2'd2,
    CFG_ROW_COUNT  = 2'd3
  } cfg_index_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_EMIT
  } state_t;

  // Group close request handed to the scale unit
  typedef struct packed {
    logic                      start;
    logic signed [GSUM_W-1:0]  gsum;
    logic [SCALE_W-1:0]        wscale;
    logic [SCALE_W-1:0]        ascale;
  } job_t;

endpackage

@@ rtl/gqdp_lane.sv @@
module gqdp_lane (
  input  logic                                  fmt,
  input  logic                                  hi_lane,
  input  logic [gqdp_pkg::BYTE_W-1:0]           wbyte,
  input  logic [gqdp_pkg::BYTE_W-1:0]           abyte,
  output logic signed [gqdp_pkg::PROD_W-1:0]    prod
);

  logic [3:0]                         w_nib;
  logic [3:0]                         a_nib;
  logic signed [gqdp_pkg::BYTE_W-1:0] w_el;
  logic signed [gqdp_pkg::BYTE_W-1:0] a_el;

  // Pick this lane's nibble
  assign w_nib = (hi_lane ? wbyte[7:4] : wbyte[3:0]) & gqdp_pkg::NIB_MASK;
  assign a_nib = (hi_lane ? abyte[7:4] : abyte[3:0]) & gqdp_pkg::NIB_MASK;

  // Decode: offset nibbles if fmt, else signed byte on high lane and zero on low
  always_comb begin
    if (fmt) begin
      w_el = $signed({4'b0000, w_nib} - gqdp_pkg::NIB_OFFSET);
      a_el = $signed({4'b0000, a_nib} - gqdp_pkg::NIB_OFFSET);
    end else if (hi_lane) begin
      w_el = $signed(wbyte);
      a_el = $signed(abyte);
    end else begin
      w_el = '0;
      a_el = '0;
    end
  end

  assign prod = w_el * a_el;

endmodule

@@ rtl/gqdp_scale.sv @@
module gqdp_scale (
  input  logic                                  clk,
  input  logic                                  rst,
  input  gqdp_pkg::job_t                        job,
  input  logic                                  row_clear,
  output logic                                  acc_done,
  output logic signed [gqdp_pkg::ROW_W-1:0]     row_sum
);

  logic                                       v1;
  logic                                       v2;
  logic signed [gqdp_pkg::GSUM_W-1:0]         gsum_q;
  logic [2*gqdp_pkg::SCALE_W-1:0]             sprod;
  logic [gqdp_pkg::QSCALE_W-1:0]              qscale;
  logic signed [gqdp_pkg::GSUM_W+gqdp_pkg::QSCALE_W:0] full_contrib;
  logic signed [gqdp_pkg::CONTRIB_W-1:0]      contrib;

  // Stage one: scale product
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= job.start;
    end
    if (job.start) begin
      gsum_q <= job.gsum;
      sprod  <= job.wscale * job.ascale;
    end
  end

  // Truncate Q8.24 to Q8.16
  assign qscale       = sprod[2*gqdp_pkg::SCALE_W-1 -: gqdp_pkg::QSCALE_W];
  assign full_contrib = gsum_q * $signed({1'b0, qscale});

  // Stage two: group sum times scale
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    if (v1) begin
      contrib <= full_contrib[gqdp_pkg::CONTRIB_W-1:0];
    end
  end

  // Stage three: add into the row sum, wrap in its width
  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum <= '0;
    end else if (row_clear) begin
      row_sum <= '0;
    end else if (v2) begin
      row_sum <= row_sum
               + {{(gqdp_pkg::ROW_W-gqdp_pkg::CONTRIB_W){contrib[gqdp_pkg::CONTRIB_W-1]}},
                  contrib};
    end
  end

  assign acc_done = v2;

endmodule

@@ rtl/group_quantized_dot_product_core.sv @@
// Group-quantized dot product core (int8 or packed int4 matrix row times vector).
// Input channel (in_valid / in_stall): one weight byte and one activation byte per
// beat; weight_scale and act_scale are sampled on the beat that closes a group.
// Output channel (out_valid / out_stall): one beat per finished row, carrying
// row_value (signed, 16 fraction bits) and matrix_done on the last row.
// Configuration channel (cfg_valid / cfg_ready, always ready): cfg_index selects
// format, group size, groups per row or row count; write only while idle.
// Throughput: one byte per cycle inside a group. The beat that closes a group
// holds the input while the two-stage scale multiplier and the row adder run;
// a beat that closes a row holds it further until the output register loads.
// After the row-closing beat the result passes the scale stages, the row adder
// and the output register. Two lanes decode the high and low nibble side by side.
// When the receiver stalls, the result waits in the output register; further
// bytes are still accepted until the next row result is ready to load.
// Reset (rst, synchronous) restores register defaults and clears all counters
// and accumulators.
module group_quantized_dot_product_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [gqdp_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [gqdp_pkg::BYTE_W-1:0]           weight_byte,
  input  logic [gqdp_pkg::BYTE_W-1:0]           act_byte,
  input  logic [gqdp_pkg::SCALE_W-1:0]          weight_scale,
  input  logic [gqdp_pkg::SCALE_W-1:0]          act_scale,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gqdp_pkg::ROW_W-1:0]     row_value,
  output logic                                  matrix_done
);

  localparam int EC_W = gqdp_pkg::EC_W;
  localparam int GC_W = gqdp_pkg::GC_W;
  localparam int RC_W = gqdp_pkg::ROW_COUNT_W;

  logic                                     weight_format;
  logic [gqdp_pkg::GRP_LEN_W-1:0]           grp_len;
  logic [gqdp_pkg::ROW_GROUPS_W-1:0]        row_groups;
  logic [RC_W-1:0]                          row_count;

  logic [EC_W-1:0]                          element_count;
  logic [EC_W-1:0]                          element_count_next;
  logic signed [gqdp_pkg::GSUM_W-1:0]       group_sum;
  logic signed [gqdp_pkg::GSUM_W-1:0]       group_sum_next;
  logic [GC_W-1:0]                          group_count;
  logic [GC_W:0]                            group_count_inc;
  logic [RC_W-1:0]                          row_counter;
  logic [RC_W:0]                            row_counter_inc;
  logic                                     row_end;

  logic [EC_W-1:0]                          gsize;
  logic [GC_W:0]                            rgroups;
  logic [RC_W-1:0]                          rows;

  logic signed [gqdp_pkg::PROD_W-1:0]       prod_hi;
  logic signed [gqdp_pkg::PROD_W-1:0]       prod_lo;
  logic signed [gqdp_pkg::PART_W-1:0]       part;

  logic                                     accept;
  logic                                     group_end;
  logic                                     row_close;
  logic                                     last_row;
  logic                                     out_free;
  logic                                     emit_load;
  logic                                     row_clear;
  logic                                     acc_done;
  logic signed [gqdp_pkg::ROW_W-1:0]        row_sum;
  gqdp_pkg::job_t                           job;
  gqdp_pkg::state_t                         state;
  gqdp_pkg::state_t                         state_next;

  function automatic logic signed [gqdp_pkg::PART_W-1:0] PART_W_ext(
    input logic signed [gqdp_pkg::PROD_W-1:0] p
  );
    PART_W_ext = {p[gqdp_pkg::PROD_W-1], p};
  endfunction

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_format <= 1'b0;
      grp_len       <= gqdp_pkg::GRP_LEN_W'(32);
      row_groups    <= gqdp_pkg::ROW_GROUPS_W'(1);
      row_count     <= RC_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (gqdp_pkg::cfg_index_t'(cfg_index))
        gqdp_pkg::CFG_FORMAT:     weight_format <= cfg_data[0];
        gqdp_pkg::CFG_GRP_LEN:    grp_len    <= cfg_data[gqdp_pkg::GRP_LEN_W-1:0];
        gqdp_pkg::CFG_ROW_GROUPS: row_groups <= cfg_data[gqdp_pkg::ROW_GROUPS_W-1:0];
        gqdp_pkg::CFG_ROW_COUNT:  row_count  <= cfg_data[RC_W-1:0];
      endcase
    end
  end

  // Clamp register values to their working ranges
  always_comb begin
    if (EC_W'(grp_len) < EC_W'(2)) begin
      gsize = EC_W'(2);
    end else if (EC_W'(grp_len) > EC_W'(gqdp_pkg::MAX_GROUP)) begin
      gsize = EC_W'(gqdp_pkg::MAX_GROUP);
    end else begin
      gsize = EC_W'(grp_len);
    end
    if (row_groups == '0) begin
      rgroups = (GC_W+1)'(1);
    end else if ((GC_W+1)'(row_groups) > (GC_W+1)'(gqdp_pkg::MAX_ROW_GROUPS)) begin
      rgroups = (GC_W+1)'(gqdp_pkg::MAX_ROW_GROUPS);
    end else begin
      rgroups = (GC_W+1)'(row_groups);
    end
    rows = (row_count == '0) ? RC_W'(1) : row_count;
  end

  // Element lanes: high nibble (or whole byte) and low nibble
  gqdp_lane u_lane_hi (
    .fmt     (weight_format),
    .hi_lane (1'b1),
    .wbyte   (weight_byte),
    .abyte   (act_byte),
    .prod    (prod_hi)
  );

  gqdp_lane u_lane_lo (
    .fmt     (weight_format),
    .hi_lane (1'b0),
    .wbyte   (weight_byte),
    .abyte   (act_byte),
    .prod    (prod_lo)
  );

  // Merge lane products into the group sum
  assign part = PART_W_ext(prod_hi) + PART_W_ext(prod_lo);

  assign group_sum_next = group_sum
                        + {{(gqdp_pkg::GSUM_W-gqdp_pkg::PART_W){part[gqdp_pkg::PART_W-1]}},
                           part};
  assign element_count_next = element_count + (weight_format ? EC_W'(2) : EC_W'(1));
  assign group_count_inc    = {1'b0, group_count} + (GC_W+1)'(1);
  assign row_counter_inc    = {1'b0, row_counter} + (RC_W+1)'(1);

  assign accept    = in_valid && !in_stall;
  assign group_end = element_count_next >= gsize;
  assign row_close = group_count_inc >= rgroups;
  assign last_row  = row_counter_inc >= {1'b0, rows};

  // Element and group counters, group sum and row end flag
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      group_sum     <= '0;
      group_count   <= '0;
      row_end       <= 1'b0;
    end else if (accept) begin
      if (group_end) begin
        element_count <= '0;
        group_sum     <= '0;
        row_end       <= row_close;
        group_count   <= row_close ? '0 : group_count_inc[GC_W-1:0];
      end else begin
        element_count <= element_count_next;
        group_sum     <= group_sum_next;
      end
    end
  end

  // Hand the closed group to the scale unit
  always_comb begin
    job.start  = accept && group_end;
    job.gsum   = group_sum_next;
    job.wscale = weight_scale;
    job.ascale = act_scale;
  end

  gqdp_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .row_clear (row_clear),
    .acc_done  (acc_done),
    .row_sum   (row_sum)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gqdp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gqdp_pkg::ST_IDLE: begin
        if (job.start) state_next = gqdp_pkg::ST_BUSY;
      end
      gqdp_pkg::ST_BUSY: begin
        if (acc_done) state_next = row_end ? gqdp_pkg::ST_EMIT : gqdp_pkg::ST_IDLE;
      end
      gqdp_pkg::ST_EMIT: begin
        if (out_free) state_next = gqdp_pkg::ST_IDLE;
      end
      default: state_next = gqdp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    emit_load = 1'b0;
    unique case (state)
      gqdp_pkg::ST_IDLE: in_stall = 1'b0;
      gqdp_pkg::ST_BUSY: in_stall = 1'b1;
      gqdp_pkg::ST_EMIT: emit_load = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  assign row_clear = emit_load;

  // Output register and row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      row_counter <= '0;
    end else if (emit_load) begin
      out_valid   <= 1'b1;
      row_counter <= last_row ? '0 : row_counter_inc[RC_W-1:0];
    end else if (!out_stall) begin
      out_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      row_value   <= row_sum;
      matrix_done <= last_row;
    end
  end

`ifndef NO_ASSERTIONS
  // The scale unit finishes only for a group that the sequencer is waiting on
  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    acc_done |-> state == gqdp_pkg::ST_BUSY)
    else $error("scale unit finished outside busy state");

  // A new result appears only after the emit state loaded it
  a_rise_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == gqdp_pkg::ST_EMIT))
    else $error("result appeared without emit");

  // Closing a group always starts the scale pipeline
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    job.start |=> state == gqdp_pkg::ST_BUSY)
    else $error("group close did not enter busy state");

  // A waiting result is never overwritten by the next row
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit_load |-> !(out_valid && out_stall))
    else $error("output register overwritten while stalled");
`endif

endmodule
